>>> design/uud_pkg.sv
`timescale 1ns / 1ps
// Package for the line decoder: character codes, decoder state and result types.
// Depends on nothing; used by uud_step, the decoder core and the testbench.
package uud_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [5:0] SPACE_CODE   = 6'd32;

  typedef struct packed {
    logic        at_line_start;
    logic [5:0]  bytes_left;
    logic [1:0]  group_position;
    logic [17:0] held_sextets;
    logic        body_finished;
  } state_t;

  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  count;
    logic        end_of_data;
  } result_t;

endpackage

>>> design/uud_char_if.sv
`timescale 1ns / 1ps
// Handshake channel that carries one encoded character per item.
// Stands alone; used by the decoder core.
interface uud_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

>>> design/uud_byte_if.sv
`timescale 1ns / 1ps
// Handshake channel that carries one decoded byte with its marker bits per item.
// Stands alone; used by the decoder core.
interface uud_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_data;
  logic       last_of_run;

  modport source (output valid, output out_byte, output end_of_data, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input end_of_data, input last_of_run,
                output ready);
endinterface

>>> design/uud_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one character of the encoded body.
// Depends on uud_pkg for the state and result types.
module uud_step (
  input  uud_pkg::state_t  cur,
  input  logic [7:0]       in_char,
  output uud_pkg::state_t  nxt,
  output uud_pkg::result_t res
);

  logic [5:0]  sextet;
  logic [23:0] word;
  logic [1:0]  take;
  logic        emit;

  assign sextet = in_char[5:0] - uud_pkg::SPACE_CODE;
  assign take = (cur.bytes_left < 6'd3) ? cur.bytes_left[1:0] : 2'd3;

  always_comb begin
    nxt = cur;
    res = '0;
    word = '0;
    emit = 1'b0;
    if (cur.body_finished) begin
      nxt = cur;
    end else if (in_char == uud_pkg::NEWLINE_CODE) begin
      if (!cur.at_line_start) begin
        if (cur.group_position != 2'd0 && cur.bytes_left != 6'd0) begin
          unique case (cur.group_position)
            2'd1:    word = {cur.held_sextets[5:0], 18'd0};
            2'd2:    word = {cur.held_sextets[11:0], 12'd0};
            default: word = {cur.held_sextets, 6'd0};
          endcase
          emit = 1'b1;
        end
        nxt.at_line_start = 1'b1;
        nxt.bytes_left = '0;
        nxt.group_position = '0;
        nxt.held_sextets = '0;
      end
    end else if (cur.at_line_start) begin
      if (sextet == 6'd0) begin
        res.count = 2'd1;
        res.end_of_data = 1'b1;
        nxt.body_finished = 1'b1;
      end else begin
        nxt.bytes_left = sextet;
        nxt.at_line_start = 1'b0;
        nxt.group_position = '0;
        nxt.held_sextets = '0;
      end
    end else if (cur.bytes_left != 6'd0) begin
      if (cur.group_position != 2'd3) begin
        nxt.held_sextets = {cur.held_sextets[11:0], sextet};
        nxt.group_position = cur.group_position + 2'd1;
      end else begin
        word = {cur.held_sextets, sextet};
        emit = 1'b1;
        nxt.group_position = '0;
        nxt.held_sextets = '0;
      end
    end
    if (emit) begin
      res.word = word;
      res.count = take;
      nxt.bytes_left = cur.bytes_left - {4'd0, take};
    end
  end

endmodule

>>> design/uu_line_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the uuencoded body decoder.
// Depends on uud_pkg, uud_char_if, uud_byte_if and uud_step.
//
// Usage: the encoded channel takes the body of a uuencoded stream, one character
// per item, starting right after the begin line. The decoded channel gives one
// data byte per item; a line whose count character is zero gives one item with
// end_of_data set and a zero byte, after which every character is dropped until
// reset. last_of_run marks the final item caused by one character.
// A character is held in an input register and is then decoded into the result
// register once that register is free; its bytes are offered from there.
// Throughput: one character per cycle while each character gives at most one
// byte and the receiver does not stall; a character that completes a group gives
// up to three bytes, which leave the result register one per cycle while the
// receiver is ready, and the next character waits until the last of them is taken.
// Reset (synchronous, active high) clears the decoder to the start of a line
// and empties both registers. When the receiver stalls, the result register
// holds its byte, the next decoded character waits in the input register and
// ready on the encoded channel drops.
module uu_line_decoder_core (
  input  logic              clk,
  input  logic              rst,
  uud_char_if.sink          encoded,
  uud_byte_if.source        decoded
);

  uud_pkg::state_t  state;
  uud_pkg::state_t  state_next;
  uud_pkg::result_t step_res;

  logic        s1_valid;
  logic [7:0]  s1_char;
  logic [23:0] res_word;
  logic [1:0]  res_count;
  logic        res_eod;
  logic [1:0]  idx;
  logic        res_last;
  logic        res_done;
  logic        res_free;
  logic        step_fire;

  uud_step u_step (
    .cur     (state),
    .in_char (s1_char),
    .nxt     (state_next),
    .res     (step_res)
  );

  assign res_last = (idx == res_count - 2'd1);
  assign res_done = decoded.valid && decoded.ready && res_last;
  assign res_free = (res_count == 2'd0) || res_done;
  assign step_fire = s1_valid && res_free;
  assign encoded.ready = !s1_valid || step_fire;

  assign decoded.valid = (res_count != 2'd0);
  assign decoded.end_of_data = res_eod;
  assign decoded.last_of_run = res_last;

  always_comb begin
    unique case (idx)
      2'd0:    decoded.out_byte = res_word[23:16];
      2'd1:    decoded.out_byte = res_word[15:8];
      default: decoded.out_byte = res_word[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (encoded.valid && encoded.ready) begin
      s1_valid <= 1'b1;
    end else if (step_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (encoded.valid && encoded.ready) begin
      s1_char <= encoded.in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{at_line_start: 1'b1, default: '0};
      res_count <= '0;
      res_eod <= 1'b0;
      idx <= '0;
    end else begin
      if (step_fire) begin
        state <= state_next;
      end
      if (step_fire && step_res.count != 2'd0) begin
        res_count <= step_res.count;
        res_eod <= step_res.end_of_data;
        idx <= '0;
      end else if (res_done) begin
        res_count <= '0;
        res_eod <= 1'b0;
        idx <= '0;
      end else if (decoded.valid && decoded.ready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && step_res.count != 2'd0) begin
      res_word <= step_res.word;
    end
  end

endmodule

>>> tb/uu_line_decoder_core_tb.sv
`timescale 1ns / 1ps
// Testbench for uu_line_decoder_core: drives lines of encoded text and checks every decoded item.
// Depends on uud_pkg, uud_char_if, uud_byte_if and the decoder core.
module uu_line_decoder_core_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
    logic       last;
  } decoded_byte_t;

  class uud_decode_tracker;
    logic        line_start = 1'b1;
    logic [5:0]  bytes_left = '0;
    logic [1:0]  held_count = '0;
    logic [17:0] held_bits  = '0;
    logic        finished   = 1'b0;
    decoded_byte_t pending[$];
    int errors = 0;

    function void push_bytes(logic [23:0] word);
      int k;
      k = (bytes_left < 6'd3) ? int'(bytes_left) : 3;
      for (int i = 0; i < k; i++) begin
        pending.push_back('{word[23 - 8 * i -: 8], 1'b0, i == k - 1});
      end
      bytes_left = bytes_left - 6'(k);
    endfunction

    function void decode_char(logic [7:0] c);
      logic [5:0] sx;
      logic [23:0] word;
      if (finished) begin
        return;
      end
      if (c == uud_pkg::NEWLINE_CODE) begin
        if (!line_start) begin
          if (held_count != 2'd0 && bytes_left != 6'd0) begin
            word = {6'd0, held_bits} << (6 * (4 - int'(held_count)));
            push_bytes(word);
          end
          line_start = 1'b1;
          bytes_left = '0;
          held_count = '0;
          held_bits = '0;
        end
        return;
      end
      sx = c[5:0] - uud_pkg::SPACE_CODE;
      if (line_start) begin
        if (sx == 6'd0) begin
          pending.push_back('{8'd0, 1'b1, 1'b1});
          finished = 1'b1;
          return;
        end
        bytes_left = sx;
        line_start = 1'b0;
        held_count = '0;
        held_bits = '0;
        return;
      end
      if (bytes_left == 6'd0) begin
        return;
      end
      if (held_count < 2'd3) begin
        held_bits = {held_bits[11:0], sx};
        held_count = held_count + 2'd1;
        return;
      end
      push_bytes({held_bits, sx});
      held_count = '0;
      held_bits = '0;
    endfunction

    function void compare_byte(logic [7:0] data, logic eod, logic last);
      decoded_byte_t want;
      if (pending.size() == 0) begin
        $error("unexpected item: out_byte %02h end_of_data %0b last_of_run %0b",
               data, eod, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.data !== data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, data);
        errors++;
      end
      if (want.eod !== eod) begin
        $error("end_of_data: expected %0b, actual %0b", want.eod, eod);
        errors++;
      end
      if (want.last !== last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  uud_char_if encoded_ch();
  uud_byte_if decoded_ch();

  uu_line_decoder_core u_dut (
    .clk(clk),
    .rst(rst),
    .encoded(encoded_ch),
    .decoded(decoded_ch)
  );

  uud_decode_tracker tracker = new();
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  bit hold_request = 1'b0;
  int items_sent = 0;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    decoded_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        decoded_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      decoded_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (decoded_ch.valid && decoded_ch.ready) begin
        tracker.compare_byte(decoded_ch.out_byte, decoded_ch.end_of_data,
                             decoded_ch.last_of_run);
      end
      if ((encoded_ch.valid && encoded_ch.ready) || (decoded_ch.valid && decoded_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      encoded_ch.valid <= 1'b0;
      @(negedge clk);
    end
    encoded_ch.valid <= 1'b1;
    encoded_ch.in_char <= c;
    forever begin
      @(posedge clk);
      if (encoded_ch.ready) break;
    end
    tracker.decode_char(c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    encoded_ch.valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending.size() != 0) @(negedge clk);
  endtask

  task automatic send_line();
    int kind;
    int n;
    int chars;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 5) begin
      send_char(uud_pkg::NEWLINE_CODE);
      return;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 12);
    c = {2'($urandom_range(3)), 6'(n + 32)};
    if (c == uud_pkg::NEWLINE_CODE) c[6] = 1'b1;
    send_char(c);
    chars = 4 * ((n + 2) / 3);
    if (kind < 20) begin
      chars = $urandom_range(0, chars);
    end else if (kind < 30) begin
      chars = chars + $urandom_range(1, 6);
    end
    for (int i = 0; i < chars; i++) begin
      c = 8'($urandom);
      if (c == uud_pkg::NEWLINE_CODE) c = c ^ 8'h40;
      send_char(c);
    end
    send_char(uud_pkg::NEWLINE_CODE);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items,
                           input bit hold_off);
    int stop_at;
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    hold_request = hold_off;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_line();
    wait_drained();
  endtask

  initial begin
    logic [7:0] opening[$];
    rst = 1'b1;
    encoded_ch.valid = 1'b0;
    encoded_ch.in_char = '0;
    opening = '{uud_pkg::NEWLINE_CODE,
                8'h23, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h41, uud_pkg::NEWLINE_CODE,
                8'hFF, 8'h5F, 8'h3F, uud_pkg::NEWLINE_CODE,
                8'h22, 8'h61, 8'h62, 8'h63, uud_pkg::NEWLINE_CODE,
                8'h21, uud_pkg::NEWLINE_CODE,
                8'h62, 8'hC0, 8'h20, 8'hFE, 8'h01, uud_pkg::NEWLINE_CODE};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (opening[i]) send_char(opening[i]);
    wait_drained();

    run_phase(0, 0, 110, 1'b1);
    run_phase(54, 0, 110, 1'b0);
    run_phase(0, 54, 110, 1'b0);
    run_phase(35, 35, 110, 1'b0);

    send_char(8'(32 + 64 * $urandom_range(3)));
    send_char(8'($urandom));
    send_char(uud_pkg::NEWLINE_CODE);
    send_char(8'h23);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
